// ----- src/rcfe_pkg.sv -----
// rcfe_pkg: shared constants, command codes, status codes and record types
// for the relay command frame executor; no dependencies
`default_nettype none

package rcfe_pkg;

	localparam int BUFFER_DEPTH = 10;
	localparam int FRAME_LEN    = 5;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [7:0] MARK_START     = 8'hAF;
	localparam logic [7:0] MARK_END       = 8'hDF;
	localparam logic [7:0] ADDR_BROADCAST = 8'hFF;

	localparam logic [7:0] CMD_OPEN         = 8'h01;
	localparam logic [7:0] CMD_CLOSE        = 8'h02;
	localparam logic [7:0] CMD_FLIP         = 8'h03;
	localparam logic [7:0] CMD_TIMER_FIRST  = 8'h04;
	localparam logic [7:0] CMD_TIMER_LAST   = 8'h08;
	localparam logic [7:0] CMD_READ_RELAYS  = 8'h09;
	localparam logic [7:0] CMD_SET_ACK      = 8'h0A;
	localparam logic [7:0] CMD_READ_POWER   = 8'hE5;
	localparam logic [7:0] CMD_SET_POWER    = 8'hE6;
	localparam logic [7:0] CMD_READ_BUTTON  = 8'hE7;
	localparam logic [7:0] CMD_SET_BUTTON   = 8'hE8;
	localparam logic [7:0] CMD_BAUD_LOW     = 8'hE9;
	localparam logic [7:0] CMD_BAUD_HIGH    = 8'hEA;
	localparam logic [7:0] CMD_READ_ADDR    = 8'hEB;
	localparam logic [7:0] CMD_SET_ADDR     = 8'hEC;

	localparam logic [2:0] ST_EMPTY    = 3'd0;
	localparam logic [2:0] ST_STORED   = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_EXECUTED = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;
	localparam logic [2:0] ST_BADLEN   = 3'd5;
	localparam logic [2:0] ST_BADMARK  = 3'd6;

	// status ST_EXECUTED here marks a well-formed frame still to be run
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] addr;
		logic [7:0] cmd;
		logic [7:0] data;
	} frame_rec_t;

endpackage

`default_nettype wire

// ----- src/rcfe_item_if.sv -----
// rcfe_item_if: input channel carrying received bytes and gap events
// no dependencies
`default_nettype none

interface rcfe_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/rcfe_result_if.sv -----
// rcfe_result_if: output channel carrying one result per input item
// no dependencies
`default_nettype none

interface rcfe_result_if;
	logic       valid;
	logic       ready;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic [1:0] relay_state;
	logic       save_request;
	logic [2:0] frame_status;

	modport source (output valid, output reply_valid, output reply_byte,
		output relay_state, output save_request, output frame_status, input ready);
	modport sink (input valid, input reply_valid, input reply_byte,
		input relay_state, input save_request, input frame_status, output ready);
endinterface

`default_nettype wire

// ----- src/rcfe_front.sv -----
// rcfe_front: byte collection and frame classification
// depends on rcfe_pkg and rcfe_item_if
`default_nettype none

module rcfe_front #(
	parameter int BUFFER_DEPTH = rcfe_pkg::BUFFER_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rcfe_item_if.sink              item,
	output rcfe_pkg::frame_rec_t   push_data,
	output logic                   push_valid,
	input  wire logic              push_ready
);
	localparam int CNT_W = $clog2(BUFFER_DEPTH);
	localparam int IDX_W = $clog2(rcfe_pkg::FRAME_LEN);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       frame_q [rcfe_pkg::FRAME_LEN];
	logic             xfer;
	logic             room;

	assign push_valid = item.valid;
	assign item.ready = push_ready;
	assign xfer       = item.valid && push_ready;
	assign room       = count_q < CNT_W'(BUFFER_DEPTH - 1);

	always_comb begin
		push_data.addr = frame_q[1];
		push_data.cmd  = frame_q[2];
		push_data.data = frame_q[3];
		if (!item.action) begin
			push_data.status = room ? rcfe_pkg::ST_STORED : rcfe_pkg::ST_DROPPED;
		end else if (count_q == '0) begin
			push_data.status = rcfe_pkg::ST_EMPTY;
		end else if (count_q != CNT_W'(rcfe_pkg::FRAME_LEN)) begin
			push_data.status = rcfe_pkg::ST_BADLEN;
		end else if (frame_q[0] != rcfe_pkg::MARK_START ||
			frame_q[rcfe_pkg::FRAME_LEN-1] != rcfe_pkg::MARK_END) begin
			push_data.status = rcfe_pkg::ST_BADMARK;
		end else begin
			push_data.status = rcfe_pkg::ST_EXECUTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (xfer) begin
			if (item.action) begin
				count_q <= '0;
			end else if (room) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// bytes past the frame length are counted while there is room but never examined
	always_ff @(posedge clk) begin
		if (xfer && !item.action && count_q < CNT_W'(rcfe_pkg::FRAME_LEN)) begin
			frame_q[count_q[IDX_W-1:0]] <= item.rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- src/rcfe_queue.sv -----
// rcfe_queue: short fifo of classified records between front and back
// depends on rcfe_pkg
`default_nettype none

module rcfe_queue #(
	parameter int DEPTH = rcfe_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  rcfe_pkg::frame_rec_t push_data,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output rcfe_pkg::frame_rec_t pop_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rcfe_pkg::frame_rec_t entry_q [DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic                 push;
	logic                 pop;

	assign push_ready = fill_q != CNT_W'(DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/rcfe_back.sv -----
// rcfe_back: address check, command execution, settings and output register
// depends on rcfe_pkg and rcfe_result_if
`default_nettype none

module rcfe_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  rcfe_pkg::frame_rec_t pop_data,
	input  wire logic            pop_valid,
	output logic                 pop_ready,
	rcfe_result_if.source        result
);
	logic [7:0] own_q, ack_en_q, power_q, button_q, ackv_q;
	logic [1:0] relays_q, remem_q;
	logic [7:0] own_n, ack_en_n, power_n, button_n, ackv_n;
	logic [1:0] relays_n, remem_n;
	logic       known, track, save;
	logic [2:0] status;
	logic       reply;
	logic       fire;

	logic       out_valid_q;
	logic       reply_valid_q;
	logic [7:0] reply_byte_q;
	logic [1:0] relay_state_q;
	logic       save_q;
	logic [2:0] status_q;

	assign pop_ready = !out_valid_q || result.ready;
	assign fire      = pop_valid && pop_ready;

	always_comb begin
		own_n    = own_q;
		ack_en_n = ack_en_q;
		power_n  = power_q;
		button_n = button_q;
		ackv_n   = ackv_q;
		relays_n = relays_q;
		remem_n  = remem_q;
		known    = 1'b0;
		track    = 1'b0;
		save     = 1'b0;
		status   = pop_data.status;
		if (pop_data.status == rcfe_pkg::ST_EXECUTED) begin
			if (pop_data.addr != rcfe_pkg::ADDR_BROADCAST && pop_data.addr != own_q) begin
				status = rcfe_pkg::ST_IGNORED;
			end else begin
				known = 1'b1;
				unique case (pop_data.cmd) inside
					rcfe_pkg::CMD_OPEN: begin
						relays_n = relays_q | pop_data.data[1:0];
						ackv_n   = 8'd1;
						track    = 1'b1;
					end
					rcfe_pkg::CMD_CLOSE: begin
						relays_n = relays_q & ~pop_data.data[1:0];
						ackv_n   = 8'd1;
						track    = 1'b1;
					end
					rcfe_pkg::CMD_FLIP: begin
						relays_n = relays_q ^ pop_data.data[1:0];
						ackv_n   = 8'd1;
					end
					[rcfe_pkg::CMD_TIMER_FIRST:rcfe_pkg::CMD_TIMER_LAST],
					rcfe_pkg::CMD_BAUD_LOW, rcfe_pkg::CMD_BAUD_HIGH: begin
						known = 1'b1;
					end
					rcfe_pkg::CMD_READ_RELAYS: ackv_n = {6'd0, relays_q};
					rcfe_pkg::CMD_SET_ACK: begin
						ack_en_n = pop_data.data;
						save     = 1'b1;
					end
					rcfe_pkg::CMD_READ_POWER: ackv_n = power_q;
					rcfe_pkg::CMD_SET_POWER: begin
						power_n = pop_data.data;
						save    = 1'b1;
					end
					rcfe_pkg::CMD_READ_BUTTON: ackv_n = button_q;
					rcfe_pkg::CMD_SET_BUTTON: begin
						button_n = pop_data.data;
						save     = 1'b1;
					end
					rcfe_pkg::CMD_READ_ADDR: ackv_n = own_q;
					rcfe_pkg::CMD_SET_ADDR: begin
						own_n = pop_data.data;
						save  = 1'b1;
					end
					default: known = 1'b0;
				endcase
				// after open or close, remember last relay state in power mode three
				if (track && power_q[1:0] == 2'b11 && remem_q != relays_n) begin
					remem_n = relays_n;
					save    = 1'b1;
				end
				if (!known) begin
					status = rcfe_pkg::ST_IGNORED;
				end
			end
		end
		reply = (status == rcfe_pkg::ST_EXECUTED) && (ack_en_n != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= 8'hFF;
			ack_en_q    <= 8'd1;
			power_q     <= 8'd0;
			button_q    <= 8'd0;
			ackv_q      <= 8'd0;
			relays_q    <= 2'd0;
			remem_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				own_q    <= own_n;
				ack_en_q <= ack_en_n;
				power_q  <= power_n;
				button_q <= button_n;
				ackv_q   <= ackv_n;
				relays_q <= relays_n;
				remem_q  <= remem_n;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			reply_valid_q <= reply;
			reply_byte_q  <= reply ? ackv_n : 8'd0;
			relay_state_q <= relays_n;
			save_q        <= save;
			status_q      <= status;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.reply_valid  = reply_valid_q;
	assign result.reply_byte   = reply_byte_q;
	assign result.relay_state  = relay_state_q;
	assign result.save_request = save_q;
	assign result.frame_status = status_q;

endmodule

`default_nettype wire

// ----- src/relay_command_frame_executor_unit.sv -----
// relay_command_frame_executor_unit: one result per input transfer; each item
// is registered in the queue, then in the output register. throughput one item
// per cycle while results are taken; the front takes items while the queue
// has room and the back drains one record per cycle into the output register.
// reset clears the byte count, queue and output valid and restores address
// 0xff, ack enable 1 and all other settings and relays to zero.
`default_nettype none

module relay_command_frame_executor_unit #(
	parameter int BUFFER_DEPTH = rcfe_pkg::BUFFER_DEPTH,
	parameter int QUEUE_DEPTH  = rcfe_pkg::QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rcfe_item_if.sink     item,
	rcfe_result_if.source result
);
	rcfe_pkg::frame_rec_t push_data;
	rcfe_pkg::frame_rec_t pop_data;
	logic                 push_valid, push_ready;
	logic                 pop_valid, pop_ready;

	rcfe_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	rcfe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	rcfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

`default_nettype wire

// ----- tb/relay_command_frame_executor_unit_tb.sv -----
// relay_command_frame_executor_unit_tb: self-checking bench for the relay command frame
// executor; drives bytes and gaps, predicts every result and compares it field by field
// depends on rcfe_pkg, rcfe_item_if, rcfe_result_if and relay_command_frame_executor_unit
`default_nettype none

module relay_command_frame_executor_unit_tb;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CALM_FROM    = 1300;
	localparam int PAUSE_AT     = 700;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [1:0] relay_state;
		logic       save_request;
		logic [2:0] frame_status;
	} outcome_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} line_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rcfe_item_if   item_if ();
	rcfe_result_if res_if ();

	relay_command_frame_executor_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if)
	);

	always #4 clk = ~clk;

	// predicted unit state
	logic [7:0] frame_bytes [rcfe_pkg::BUFFER_DEPTH-1];
	int         held;
	logic [7:0] own_addr;
	logic [7:0] ack_en;
	logic [7:0] power_mode;
	logic [7:0] button_mode;
	logic [1:0] saved_relays;
	logic [1:0] relays;
	logic [7:0] ack_val;

	line_item_t line_items[$];
	outcome_t   pending_outcomes[$];
	int         errors = 0;
	int         queued = 0;
	int         accepted_items = 0;
	int         cycles = 0;
	bit         calm = 0;

	function automatic logic remember_relays();
		if (power_mode[1:0] == 2'b11 && saved_relays != relays) begin
			saved_relays = relays;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic outcome_t apply_rx_item(input logic act, input logic [7:0] b);
		outcome_t   o;
		logic [7:0] cmd;
		logic [7:0] dat;
		logic [1:0] sel;
		logic       known;
		o = '0;
		if (!act) begin
			if (held < rcfe_pkg::BUFFER_DEPTH - 1) begin
				frame_bytes[held] = b;
				held++;
				o.frame_status = rcfe_pkg::ST_STORED;
			end else begin
				o.frame_status = rcfe_pkg::ST_DROPPED;
			end
		end else if (held == 0) begin
			o.frame_status = rcfe_pkg::ST_EMPTY;
		end else begin
			if (held != rcfe_pkg::FRAME_LEN) begin
				o.frame_status = rcfe_pkg::ST_BADLEN;
			end else if (frame_bytes[0] != rcfe_pkg::MARK_START ||
				frame_bytes[rcfe_pkg::FRAME_LEN-1] != rcfe_pkg::MARK_END) begin
				o.frame_status = rcfe_pkg::ST_BADMARK;
			end else if (frame_bytes[1] != rcfe_pkg::ADDR_BROADCAST &&
				frame_bytes[1] != own_addr) begin
				o.frame_status = rcfe_pkg::ST_IGNORED;
			end else begin
				cmd = frame_bytes[2];
				dat = frame_bytes[3];
				sel = dat[1:0];
				known = 1'b1;
				case (cmd)
					rcfe_pkg::CMD_OPEN: begin
						relays = relays | sel;
						o.save_request = remember_relays();
						ack_val = 8'd1;
					end
					rcfe_pkg::CMD_CLOSE: begin
						relays = relays & ~sel;
						o.save_request = remember_relays();
						ack_val = 8'd1;
					end
					rcfe_pkg::CMD_FLIP: begin
						relays = relays ^ sel;
						ack_val = 8'd1;
					end
					rcfe_pkg::CMD_READ_RELAYS: ack_val = {6'd0, relays};
					rcfe_pkg::CMD_SET_ACK: begin
						ack_en = dat;
						o.save_request = 1'b1;
					end
					rcfe_pkg::CMD_READ_POWER: ack_val = power_mode;
					rcfe_pkg::CMD_SET_POWER: begin
						power_mode = dat;
						o.save_request = 1'b1;
					end
					rcfe_pkg::CMD_READ_BUTTON: ack_val = button_mode;
					rcfe_pkg::CMD_SET_BUTTON: begin
						button_mode = dat;
						o.save_request = 1'b1;
					end
					rcfe_pkg::CMD_READ_ADDR: ack_val = own_addr;
					rcfe_pkg::CMD_SET_ADDR: begin
						own_addr = dat;
						o.save_request = 1'b1;
					end
					default: known = (cmd >= rcfe_pkg::CMD_TIMER_FIRST &&
						cmd <= rcfe_pkg::CMD_TIMER_LAST) ||
						cmd == rcfe_pkg::CMD_BAUD_LOW || cmd == rcfe_pkg::CMD_BAUD_HIGH;
				endcase
				if (known) begin
					o.frame_status = rcfe_pkg::ST_EXECUTED;
					o.reply_valid = (ack_en != 8'd0);
					o.reply_byte = o.reply_valid ? ack_val : 8'd0;
				end else begin
					o.frame_status = rcfe_pkg::ST_IGNORED;
				end
			end
			held = 0;
		end
		o.relay_state = relays;
		return o;
	endfunction

	task automatic push_line(input logic act, input logic [7:0] b);
		line_items.push_back('{action: act, rx_byte: b});
		queued++;
	endtask

	task automatic push_frame(input logic [7:0] first, input logic [7:0] addr,
		input logic [7:0] cmd, input logic [7:0] dat, input logic [7:0] last);
		push_line(1'b0, first);
		push_line(1'b0, addr);
		push_line(1'b0, cmd);
		push_line(1'b0, dat);
		push_line(1'b0, last);
		push_line(1'b1, 8'($urandom));
	endtask

	function automatic logic [7:0] pick_command();
		int k;
		k = $urandom_range(0, 19);
		if (k < 10)
			return 8'(rcfe_pkg::CMD_OPEN + k);
		if (k < 18)
			return 8'(rcfe_pkg::CMD_READ_POWER + (k - 10));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_data();
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_addr();
		case ($urandom_range(0, 2))
			0: return rcfe_pkg::ADDR_BROADCAST;
			1: return own_addr;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// input driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.action <= 1'b0;
			item_if.rx_byte <= 8'd0;
			send_gap <= 0;
		end else if (!item_if.valid || item_if.ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				item_if.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				send_gap <= $urandom_range(0, 15);
				item_if.valid <= 1'b0;
			end else if (line_items.size() != 0) begin
				line_item_t li;
				li = line_items.pop_front();
				item_if.valid <= 1'b1;
				item_if.action <= li.action;
				item_if.rx_byte <= li.rx_byte;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off
	int  stall_left;
	int  hold_left;
	bit  hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_if.ready <= 1'b0;
		end else if (!hold_done && accepted_items >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_if.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 15);
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// results are checked before the same-edge input transfer is predicted
	always @(posedge clk) begin : scoreboard
		outcome_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (pending_outcomes.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing expected, actual status %0h",
						$time, res_if.frame_status);
				end else begin
					want = pending_outcomes.pop_front();
					check_field("reply_valid", 8'(want.reply_valid), 8'(res_if.reply_valid));
					check_field("reply_byte", want.reply_byte, res_if.reply_byte);
					check_field("relay_state", 8'(want.relay_state), 8'(res_if.relay_state));
					check_field("save_request", 8'(want.save_request),
						8'(res_if.save_request));
					check_field("frame_status", 8'(want.frame_status),
						8'(res_if.frame_status));
				end
			end
			if (item_if.valid && item_if.ready) begin
				pending_outcomes.push_back(apply_rx_item(item_if.action, item_if.rx_byte));
				accepted_items++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("relay_command_frame_executor_unit test failed");
			$finish;
		end
	end

	initial begin
		int         kind;
		int         n;
		logic [7:0] first;
		logic [7:0] last;
		bit         paused;
		paused = 0;
		item_if.valid = 1'b0;
		item_if.action = 1'b0;
		item_if.rx_byte = 8'd0;
		res_if.ready = 1'b0;
		held = 0;
		own_addr = rcfe_pkg::ADDR_BROADCAST;
		ack_en = 8'd1;
		power_mode = 8'd0;
		button_mode = 8'd0;
		saved_relays = 2'd0;
		relays = 2'd0;
		ack_val = 8'd0;
		foreach (frame_bytes[i])
			frame_bytes[i] = 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty gap, broadcast open, overflow with drop, foreign address
		push_line(1'b1, 8'hFF);
		push_frame(rcfe_pkg::MARK_START, rcfe_pkg::ADDR_BROADCAST, rcfe_pkg::CMD_OPEN, 8'hFF,
			rcfe_pkg::MARK_END);
		for (int i = 0; i < rcfe_pkg::BUFFER_DEPTH; i++)
			push_line(1'b0, (i % 2) ? 8'hFF : 8'h00);
		push_line(1'b1, 8'h00);
		push_frame(rcfe_pkg::MARK_START, 8'h00, rcfe_pkg::CMD_CLOSE, 8'h03, rcfe_pkg::MARK_END);

		while (queued < RANDOM_ITEMS) begin
			while (line_items.size() > 8)
				@(posedge clk);
			if (!paused && queued >= PAUSE_AT) begin
				paused = 1;
				while (line_items.size() != 0 || item_if.valid || pending_outcomes.size() != 0)
					@(posedge clk);
			end
			calm = (queued >= CALM_FROM);
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				push_frame(rcfe_pkg::MARK_START, pick_addr(), pick_command(), pick_data(),
					rcfe_pkg::MARK_END);
			end else if (kind < 16) begin
				first = $urandom_range(0, 1) ? rcfe_pkg::MARK_START : 8'($urandom_range(0, 255));
				last = (first == rcfe_pkg::MARK_START || $urandom_range(0, 1)) ?
					8'($urandom_range(0, 255)) : rcfe_pkg::MARK_END;
				push_frame(first, pick_addr(), pick_command(), pick_data(), last);
			end else if (kind < 18) begin
				n = $urandom_range(1, 12);
				if (n == rcfe_pkg::FRAME_LEN)
					n++;
				for (int i = 0; i < n; i++)
					push_line(1'b0, (i == 0 && $urandom_range(0, 1)) ? rcfe_pkg::MARK_START :
						8'($urandom_range(0, 255)));
				push_line(1'b1, 8'($urandom));
			end else if ($urandom_range(0, 1)) begin
				push_line(1'b1, 8'($urandom));
			end else begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					push_line(1'b0, 8'($urandom));
			end
		end
		push_line(1'b1, 8'h00);

		while (line_items.size() != 0 || item_if.valid || pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_outcomes.size());
		end
		if (errors == 0)
			$display("relay_command_frame_executor_unit test passed");
		else
			$display("relay_command_frame_executor_unit test failed");
		$finish;
	end

endmodule

`default_nettype wire
